// File: rtl/dbcs_pkg.sv
// Shared types and constants for the double-byte character set decoder.
// Used by the front end, back end, top level and checker; depends on nothing.
`timescale 1ns / 1ps

package dbcs_pkg;

   typedef enum logic [2:0] {
      REQ_DECODE         = 3'd0,
      REQ_WRITE_MAIN     = 3'd1,
      REQ_WRITE_FALLBACK = 3'd2,
      REQ_WRITE_LEAD     = 3'd3,
      REQ_FLUSH          = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      STATUS_UNIT       = 2'd0,
      STATUS_UNASSIGNED = 2'd1,
      STATUS_TRUNCATED  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_LOOKUP         = 2'd0,
      OP_WRITE_MAIN     = 2'd1,
      OP_WRITE_FALLBACK = 2'd2,
      OP_TRUNCATE       = 2'd3
   } op_type;

   typedef enum logic {
      CSR_USE_FALLBACK     = 1'b0,
      CSR_FALLBACK_PRESENT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [7:0]  data_byte;
      logic [15:0] table_index;
      logic [15:0] table_value;
      logic        lead_flag;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] code_unit;
      logic [15:0] bad_bytes;
      logic [1:0]  bad_length;
   } rsp_word_type;

   typedef struct packed {
      op_type      op;
      logic [15:0] key;
      logic [15:0] value;
   } work_type;

   typedef struct packed {
      logic use_fallback;
      logic fallback_present;
   } csr_type;

   localparam logic [15:0] MISSING_UNIT = 16'hFFFD;

   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH) + 1;
   localparam int OUT_DEPTH        = 4;
   localparam int OUT_COUNT_BITS   = $clog2(OUT_DEPTH) + 1;

endpackage

// File: rtl/dbcs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module dbcs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/dbcs_fifo.sv
// Small register-based FIFO with an occupancy count.
// Depends on nothing.
`timescale 1ns / 1ps

module dbcs_fifo #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 4,
   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int COUNT_BITS = $clog2(DEPTH) + 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [WIDTH-1:0]      push_data,
   input  logic                  pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic [COUNT_BITS-1:0] count,
   output logic                  not_empty
);

   logic [WIDTH-1:0]      entries_ff [DEPTH];
   logic [PTR_BITS-1:0]   head_ff, head_in;
   logic [PTR_BITS-1:0]   tail_ff, tail_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (pop) begin
         head_in = (head_ff == PTR_BITS'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (push) begin
         tail_in = (tail_ff == PTR_BITS'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[tail_ff] <= push_data;
      end
   end

   assign pop_data  = entries_ff[head_ff];
   assign count     = count_ff;
   assign not_empty = (count_ff != '0);

endmodule

// File: rtl/dbcs_front.sv
// Front end: accepts request words, looks up the lead-byte flags and tracks the
// pending lead. Depends on dbcs_pkg and dbcs_ram.
`timescale 1ns / 1ps

module dbcs_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  dbcs_pkg::req_word_type                req_data,
   input  logic [dbcs_pkg::QUEUE_COUNT_BITS-1:0] queue_count,
   output logic                                  push,
   output dbcs_pkg::work_type                    push_data
);

   localparam int SUM_BITS = dbcs_pkg::QUEUE_COUNT_BITS + 1;

   logic                   accept;
   logic                   flag_rd;
   logic [SUM_BITS-1:0]    room_sum;
   logic                   a_valid_ff;
   dbcs_pkg::req_word_type a_req_ff;
   logic [7:0]             pending_lead_ff, pending_lead_in;
   logic                   push_in;
   dbcs_pkg::work_type     work_in;

   assign room_sum  = SUM_BITS'(queue_count) + SUM_BITS'(a_valid_ff);
   assign req_ready = (room_sum < SUM_BITS'(dbcs_pkg::QUEUE_DEPTH));
   assign accept    = req_valid && req_ready;

   dbcs_ram #(
      .WIDTH (1),
      .DEPTH (256)
   ) u_lead_flags (
      .clock   (clock),
      .wr_en   (accept && (req_data.req_type == dbcs_pkg::REQ_WRITE_LEAD)),
      .wr_addr (req_data.table_index[7:0]),
      .wr_data (req_data.lead_flag),
      .rd_en   (accept && (req_data.req_type == dbcs_pkg::REQ_DECODE)),
      .rd_addr (req_data.data_byte),
      .rd_data (flag_rd)
   );

   always_comb begin
      push_in         = 1'b0;
      work_in         = '0;
      pending_lead_in = pending_lead_ff;
      if (a_valid_ff) begin
         unique case (a_req_ff.req_type)
            dbcs_pkg::REQ_DECODE: begin
               if (flag_rd && (pending_lead_ff == 8'd0)) begin
                  pending_lead_in = a_req_ff.data_byte;
               end else begin
                  push_in         = 1'b1;
                  work_in.op      = dbcs_pkg::OP_LOOKUP;
                  work_in.key     = {pending_lead_ff, a_req_ff.data_byte};
                  pending_lead_in = 8'd0;
               end
            end
            dbcs_pkg::REQ_WRITE_MAIN: begin
               push_in       = 1'b1;
               work_in.op    = dbcs_pkg::OP_WRITE_MAIN;
               work_in.key   = a_req_ff.table_index;
               work_in.value = a_req_ff.table_value;
            end
            dbcs_pkg::REQ_WRITE_FALLBACK: begin
               push_in       = 1'b1;
               work_in.op    = dbcs_pkg::OP_WRITE_FALLBACK;
               work_in.key   = a_req_ff.table_index;
               work_in.value = a_req_ff.table_value;
            end
            dbcs_pkg::REQ_WRITE_LEAD: begin
               push_in = 1'b0;
            end
            dbcs_pkg::REQ_FLUSH: begin
               if (pending_lead_ff != 8'd0) begin
                  push_in         = 1'b1;
                  work_in.op      = dbcs_pkg::OP_TRUNCATE;
                  pending_lead_in = 8'd0;
               end
            end
            default: begin
               push_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff      <= 1'b0;
         pending_lead_ff <= 8'd0;
      end else begin
         a_valid_ff      <= accept;
         pending_lead_ff <= pending_lead_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_req_ff <= req_data;
      end
   end

   assign push      = push_in;
   assign push_data = work_in;

endmodule

// File: rtl/dbcs_back.sv
// Back end: carries out map writes and lookups against the main and fallback
// maps and buffers result words. Depends on dbcs_pkg, dbcs_ram and dbcs_fifo.
`timescale 1ns / 1ps

module dbcs_back #(
   parameter int KEY_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dbcs_pkg::csr_type      csr,
   input  logic                   queue_not_empty,
   input  dbcs_pkg::work_type     queue_data,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output dbcs_pkg::rsp_word_type rsp_data
);

   localparam int SUM_BITS = dbcs_pkg::OUT_COUNT_BITS + 1;
   localparam int RSP_BITS = $bits(dbcs_pkg::rsp_word_type);

   logic [dbcs_pkg::OUT_COUNT_BITS-1:0] out_count;
   logic [SUM_BITS-1:0]                 flight_sum;
   logic [15:0]                         main_rd;
   logic [15:0]                         fallback_rd;
   logic                                b2_valid_ff;
   dbcs_pkg::work_type                  b2_work_ff;
   logic                                b3_valid_ff;
   dbcs_pkg::work_type                  b3_work_ff;
   logic [15:0]                         b3_main_ff;
   logic [15:0]                         unit;
   logic                                out_push;
   dbcs_pkg::rsp_word_type              result;
   logic [RSP_BITS-1:0]                 out_head;

   assign flight_sum = SUM_BITS'(out_count) + SUM_BITS'(b2_valid_ff)
                     + SUM_BITS'(b3_valid_ff);
   assign pop = queue_not_empty && (flight_sum < SUM_BITS'(dbcs_pkg::OUT_DEPTH));

   dbcs_ram #(
      .WIDTH (16),
      .DEPTH (1 << KEY_BITS)
   ) u_main_map (
      .clock   (clock),
      .wr_en   (pop && (queue_data.op == dbcs_pkg::OP_WRITE_MAIN)),
      .wr_addr (queue_data.key[KEY_BITS-1:0]),
      .wr_data (queue_data.value),
      .rd_en   (pop && (queue_data.op == dbcs_pkg::OP_LOOKUP)),
      .rd_addr (queue_data.key[KEY_BITS-1:0]),
      .rd_data (main_rd)
   );

   dbcs_ram #(
      .WIDTH (16),
      .DEPTH (1 << KEY_BITS)
   ) u_fallback_map (
      .clock   (clock),
      .wr_en   (b2_valid_ff && (b2_work_ff.op == dbcs_pkg::OP_WRITE_FALLBACK)),
      .wr_addr (b2_work_ff.key[KEY_BITS-1:0]),
      .wr_data (b2_work_ff.value),
      .rd_en   (b2_valid_ff && (b2_work_ff.op == dbcs_pkg::OP_LOOKUP)),
      .rd_addr (b2_work_ff.key[KEY_BITS-1:0]),
      .rd_data (fallback_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
      end else begin
         b2_valid_ff <= pop;
         b3_valid_ff <= b2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b2_work_ff <= queue_data;
      end
      if (b2_valid_ff) begin
         b3_work_ff <= b2_work_ff;
         b3_main_ff <= main_rd;
      end
   end

   always_comb begin
      result = '0;
      unit   = b3_main_ff;
      if ((b3_main_ff == dbcs_pkg::MISSING_UNIT) && csr.use_fallback
          && csr.fallback_present) begin
         unit = fallback_rd;
      end
      if (b3_work_ff.op == dbcs_pkg::OP_TRUNCATE) begin
         result.status = dbcs_pkg::STATUS_TRUNCATED;
      end else if (unit != dbcs_pkg::MISSING_UNIT) begin
         result.status    = dbcs_pkg::STATUS_UNIT;
         result.code_unit = unit;
      end else begin
         result.status     = dbcs_pkg::STATUS_UNASSIGNED;
         result.bad_bytes  = b3_work_ff.key;
         result.bad_length = (b3_work_ff.key[15:8] != 8'd0) ? 2'd2 : 2'd1;
      end
   end

   assign out_push = b3_valid_ff && ((b3_work_ff.op == dbcs_pkg::OP_LOOKUP)
                                  || (b3_work_ff.op == dbcs_pkg::OP_TRUNCATE));

   dbcs_fifo #(
      .WIDTH (RSP_BITS),
      .DEPTH (dbcs_pkg::OUT_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (result),
      .pop       (rsp_valid && rsp_ready),
      .pop_data  (out_head),
      .count     (out_count),
      .not_empty (rsp_valid)
   );

   assign rsp_data = dbcs_pkg::rsp_word_type'(out_head);

endmodule

// File: rtl/dbcs_to_unicode_decoder.sv
// A decode word passes the lead-flag stage, work queue, map stages and result FIFO in order.
// Throughput: one word per cycle while the queues have room and rsp is not stalled.
// Lead-flag, main, fallback maps: 1W1R RAMs, each port used once per word in fixed stages.
// Reset is synchronous: it clears the pending lead, queues and configuration registers.
// The map and lead-flag contents are not cleared and read undefined until written.
`timescale 1ns / 1ps

module dbcs_to_unicode_decoder #(
   parameter int KEY_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  dbcs_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output dbcs_pkg::rsp_word_type rsp_data,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   localparam int WORK_BITS = $bits(dbcs_pkg::work_type);

   logic                                  push;
   dbcs_pkg::work_type                    push_data;
   logic                                  pop;
   logic [WORK_BITS-1:0]                  queue_head;
   logic [dbcs_pkg::QUEUE_COUNT_BITS-1:0] queue_count;
   logic                                  queue_not_empty;
   logic                                  use_fallback_ff, use_fallback_in;
   logic                                  fallback_present_ff, fallback_present_in;
   dbcs_pkg::csr_index_type               csr_index;
   dbcs_pkg::csr_type                     csr;

   assign pready    = 1'b1;
   assign csr_index = dbcs_pkg::csr_index_type'(paddr[2]);

   always_comb begin
      use_fallback_in     = use_fallback_ff;
      fallback_present_in = fallback_present_ff;
      if (psel && penable && pwrite && pready) begin
         unique case (csr_index)
            dbcs_pkg::CSR_USE_FALLBACK:     use_fallback_in     = pwdata[0];
            dbcs_pkg::CSR_FALLBACK_PRESENT: fallback_present_in = pwdata[0];
            default:                        use_fallback_in     = use_fallback_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         dbcs_pkg::CSR_USE_FALLBACK:     prdata = {31'd0, use_fallback_ff};
         dbcs_pkg::CSR_FALLBACK_PRESENT: prdata = {31'd0, fallback_present_ff};
         default:                        prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_fallback_ff     <= 1'b0;
         fallback_present_ff <= 1'b0;
      end else begin
         use_fallback_ff     <= use_fallback_in;
         fallback_present_ff <= fallback_present_in;
      end
   end

   assign csr.use_fallback     = use_fallback_ff;
   assign csr.fallback_present = fallback_present_ff;

   dbcs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .queue_count (queue_count),
      .push        (push),
      .push_data   (push_data)
   );

   dbcs_fifo #(
      .WIDTH (WORK_BITS),
      .DEPTH (dbcs_pkg::QUEUE_DEPTH)
   ) u_work_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (queue_head),
      .count     (queue_count),
      .not_empty (queue_not_empty)
   );

   dbcs_back #(
      .KEY_BITS (KEY_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .csr             (csr),
      .queue_not_empty (queue_not_empty),
      .queue_data      (dbcs_pkg::work_type'(queue_head)),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data)
   );

endmodule

// File: rtl/dbcs_checker.sv
// Port-level checker for the decoder and the bind that attaches it.
// Depends on dbcs_pkg and dbcs_to_unicode_decoder.
`timescale 1ns / 1ps

module dbcs_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input dbcs_pkg::rsp_word_type rsp_data
);

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word visible right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed or dropped");

   a_unit_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == dbcs_pkg::STATUS_UNIT)
      |-> (rsp_data.bad_bytes == 16'd0) && (rsp_data.bad_length == 2'd0))
      else $error("decoded word carries offending bytes");

   a_unassigned_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == dbcs_pkg::STATUS_UNASSIGNED)
      |-> (rsp_data.code_unit == 16'd0)
          && (((rsp_data.bad_bytes[15:8] != 8'd0) && (rsp_data.bad_length == 2'd2))
           || ((rsp_data.bad_bytes[15:8] == 8'd0) && (rsp_data.bad_length == 2'd1))))
      else $error("unassigned word has inconsistent length");

   a_truncated_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == dbcs_pkg::STATUS_TRUNCATED)
      |-> (rsp_data.code_unit == 16'd0) && (rsp_data.bad_bytes == 16'd0)
          && (rsp_data.bad_length == 2'd0))
      else $error("truncated word carries data");

endmodule

bind dbcs_to_unicode_decoder dbcs_checker u_dbcs_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
